>>> src/kdl_pkg.sv
`timescale 1ns / 1ps

package kdl_pkg;

    // Default code length in digits.
    localparam int CODE_LENGTH_DEF = 5;

    // Register reset values.
    localparam logic [7:0] MOTOR_SECONDS_RST   = 8'd15;
    localparam logic [7:0] ALARM_SECONDS_RST   = 8'd60;
    localparam logic [7:0] LOCKOUT_SECONDS_RST = 8'd60;
    localparam logic [3:0] MAX_FAULTS_RST      = 4'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_MOTOR_SECONDS   = 2'd0;
    localparam logic [1:0] CFG_ALARM_SECONDS   = 2'd1;
    localparam logic [1:0] CFG_LOCKOUT_SECONDS = 2'd2;
    localparam logic [1:0] CFG_MAX_FAULTS      = 2'd3;

    // Sync bytes exchanged with the keypad unit.
    localparam logic [7:0] SYNC_PARTNER_READY = 8'h01;
    localparam logic [7:0] SYNC_SELF_READY    = 8'h10;
    localparam logic [7:0] SYNC_ENTER         = 8'h02;
    localparam logic [7:0] SYNC_CONFIRM       = 8'h03;
    localparam logic [7:0] SYNC_STEP          = 8'h03;
    localparam logic [7:0] SYNC_OPEN          = 8'h04;
    localparam logic [7:0] SYNC_CLOSE         = 8'h05;
    localparam logic [7:0] SYNC_MAIN          = 8'h06;
    localparam logic [7:0] SYNC_FAULT         = 8'h11;

    // Key choices.
    localparam logic [7:0] KEY_OPEN   = 8'h2A;
    localparam logic [7:0] KEY_CHANGE = 8'h23;

    // Result slot selectors.
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    localparam logic [1:0] COUNT_ONE   = 2'd1;
    localparam logic [1:0] COUNT_TWO   = 2'd2;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    typedef enum logic [8:0] {
        PH_WAIT    = 9'b000000001,
        PH_FIRST   = 9'b000000010,
        PH_CONFIRM = 9'b000000100,
        PH_KEY     = 9'b000001000,
        PH_ENTRY   = 9'b000010000,
        PH_OPENING = 9'b000100000,
        PH_CLOSING = 9'b001000000,
        PH_ALARM   = 9'b010000000,
        PH_LOCKOUT = 9'b100000000
    } phase_t;

    // All result beats caused by one input item.
    typedef struct packed {
        logic [1:0]      count;
        logic            has_tx;
        logic [7:0]      byte2;
        logic [7:0]      byte1;
        logic [7:0]      byte0;
        logic            motor_open;
        logic            motor_close;
        logic            buzzer;
    } pkt_t;

endpackage

>>> src/kdl_core.sv
`timescale 1ns / 1ps

module kdl_core #(
    parameter int CODE_LENGTH = kdl_pkg::CODE_LENGTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_acc,
    input  logic          command,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    motor_seconds,
    input  logic [7:0]    alarm_seconds,
    input  logic [7:0]    lockout_seconds,
    input  logic [3:0]    max_faults,
    output kdl_pkg::pkt_t pkt
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [CNT_W-1:0] CODE_LEN_C = CNT_W'(CODE_LENGTH);

    kdl_pkg::phase_t  phase_reg, phase_next;
    logic [CNT_W-1:0] digit_index_reg, digit_index_next;
    logic             mismatch_seen_reg, mismatch_seen_next;
    logic [3:0]       fault_count_reg, fault_count_next;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic [7:0]       chosen_key_reg, chosen_key_next;
    logic [7:0]       first_entry_reg [CODE_LENGTH];
    logic [7:0]       stored_code_reg [CODE_LENGTH];

    logic             first_we;
    logic             copy_en;
    logic [7:0]       tick_inc;
    logic [3:0]       fault_inc;
    logic [CNT_W-1:0] digit_inc;
    logic             digit_ok;
    logic             code_done;
    logic [IDX_W-1:0] rd_idx;
    logic             first_diff;
    logic             stored_diff;

    assign rd_idx      = digit_index_reg[IDX_W-1:0];
    assign digit_ok    = digit_index_reg < CODE_LEN_C;
    assign digit_inc   = digit_index_reg + CNT_W'(1);
    assign code_done   = digit_inc >= CODE_LEN_C;
    assign first_diff  = digit_ok && (first_entry_reg[rd_idx] != rx_byte);
    assign stored_diff = digit_ok && (stored_code_reg[rd_idx] != rx_byte);
    assign tick_inc    = (tick_count_reg == 8'hFF) ? tick_count_reg : tick_count_reg + 8'd1;
    assign fault_inc   = (fault_count_reg == 4'hF) ? fault_count_reg
                                                   : fault_count_reg + 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        digit_index_next   = digit_index_reg;
        mismatch_seen_next = mismatch_seen_reg;
        fault_count_next   = fault_count_reg;
        tick_count_next    = tick_count_reg;
        chosen_key_next    = chosen_key_reg;
        first_we           = 1'b0;
        copy_en            = 1'b0;
        pkt                = '0;
        pkt.count          = kdl_pkg::COUNT_ONE;

        if (command)
        begin
            case (phase_reg)
                kdl_pkg::PH_OPENING:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= motor_seconds)
                    begin
                        phase_next      = kdl_pkg::PH_CLOSING;
                        tick_count_next = 8'd0;
                        pkt.has_tx      = 1'b1;
                        pkt.byte0       = kdl_pkg::SYNC_CLOSE;
                    end
                end
                kdl_pkg::PH_CLOSING:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= motor_seconds)
                    begin
                        tick_count_next    = 8'd0;
                        fault_count_next   = 4'd0;
                        phase_next         = kdl_pkg::PH_KEY;
                        digit_index_next   = '0;
                        mismatch_seen_next = 1'b0;
                        pkt.has_tx         = 1'b1;
                        pkt.count          = kdl_pkg::COUNT_TWO;
                        pkt.byte0          = kdl_pkg::SYNC_STEP;
                        pkt.byte1          = kdl_pkg::SYNC_MAIN;
                    end
                end
                kdl_pkg::PH_ALARM:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= alarm_seconds)
                    begin
                        phase_next      = kdl_pkg::PH_LOCKOUT;
                        tick_count_next = 8'd0;
                        pkt.has_tx      = 1'b1;
                        pkt.byte0       = kdl_pkg::SYNC_FAULT;
                    end
                end
                kdl_pkg::PH_LOCKOUT:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= lockout_seconds)
                    begin
                        tick_count_next    = 8'd0;
                        fault_count_next   = 4'd0;
                        phase_next         = kdl_pkg::PH_KEY;
                        digit_index_next   = '0;
                        mismatch_seen_next = 1'b0;
                        pkt.has_tx         = 1'b1;
                        pkt.count          = kdl_pkg::COUNT_THREE;
                        pkt.byte0          = kdl_pkg::SYNC_MAIN;
                        pkt.byte1          = kdl_pkg::SYNC_STEP;
                        pkt.byte2          = kdl_pkg::SYNC_MAIN;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                kdl_pkg::PH_WAIT:
                begin
                    if (rx_byte == kdl_pkg::SYNC_PARTNER_READY)
                    begin
                        phase_next         = kdl_pkg::PH_FIRST;
                        digit_index_next   = '0;
                        mismatch_seen_next = 1'b0;
                        pkt.has_tx         = 1'b1;
                        pkt.count          = kdl_pkg::COUNT_TWO;
                        pkt.byte0          = kdl_pkg::SYNC_SELF_READY;
                        pkt.byte1          = kdl_pkg::SYNC_ENTER;
                    end
                end
                kdl_pkg::PH_FIRST:
                begin
                    first_we         = digit_ok;
                    digit_index_next = digit_inc;
                    if (code_done)
                    begin
                        phase_next         = kdl_pkg::PH_CONFIRM;
                        digit_index_next   = '0;
                        mismatch_seen_next = 1'b0;
                        pkt.has_tx         = 1'b1;
                        pkt.byte0          = kdl_pkg::SYNC_CONFIRM;
                    end
                end
                kdl_pkg::PH_CONFIRM:
                begin
                    mismatch_seen_next = mismatch_seen_reg | first_diff;
                    digit_index_next   = digit_inc;
                    if (code_done)
                    begin
                        digit_index_next   = '0;
                        mismatch_seen_next = 1'b0;
                        pkt.has_tx         = 1'b1;
                        if (mismatch_seen_reg | first_diff)
                        begin
                            phase_next = kdl_pkg::PH_FIRST;
                            pkt.byte0  = kdl_pkg::SYNC_ENTER;
                        end
                        else
                        begin
                            copy_en          = 1'b1;
                            fault_count_next = 4'd0;
                            phase_next       = kdl_pkg::PH_KEY;
                            pkt.count        = kdl_pkg::COUNT_TWO;
                            pkt.byte0        = kdl_pkg::SYNC_STEP;
                            pkt.byte1        = kdl_pkg::SYNC_MAIN;
                        end
                    end
                end
                kdl_pkg::PH_KEY:
                begin
                    chosen_key_next    = rx_byte;
                    phase_next         = kdl_pkg::PH_ENTRY;
                    digit_index_next   = '0;
                    mismatch_seen_next = 1'b0;
                end
                kdl_pkg::PH_ENTRY:
                begin
                    mismatch_seen_next = mismatch_seen_reg | stored_diff;
                    digit_index_next   = digit_inc;
                    if (code_done)
                    begin
                        if (!(mismatch_seen_reg | stored_diff))
                        begin
                            fault_count_next = 4'd0;
                            pkt.has_tx       = 1'b1;
                            if (chosen_key_reg == kdl_pkg::KEY_OPEN)
                            begin
                                phase_next      = kdl_pkg::PH_OPENING;
                                tick_count_next = 8'd0;
                                pkt.byte0       = kdl_pkg::SYNC_OPEN;
                            end
                            else if (chosen_key_reg == kdl_pkg::KEY_CHANGE)
                            begin
                                phase_next         = kdl_pkg::PH_FIRST;
                                digit_index_next   = '0;
                                mismatch_seen_next = 1'b0;
                                pkt.byte0          = kdl_pkg::SYNC_ENTER;
                            end
                            else
                            begin
                                phase_next         = kdl_pkg::PH_KEY;
                                digit_index_next   = '0;
                                mismatch_seen_next = 1'b0;
                                pkt.count          = kdl_pkg::COUNT_TWO;
                                pkt.byte0          = kdl_pkg::SYNC_STEP;
                                pkt.byte1          = kdl_pkg::SYNC_MAIN;
                            end
                        end
                        else
                        begin
                            fault_count_next = fault_inc;
                            if (fault_inc >= max_faults)
                            begin
                                // The alarm starts silently on the sync channel.
                                phase_next      = kdl_pkg::PH_ALARM;
                                tick_count_next = 8'd0;
                            end
                            else
                            begin
                                phase_next         = kdl_pkg::PH_KEY;
                                digit_index_next   = '0;
                                mismatch_seen_next = 1'b0;
                                pkt.has_tx         = 1'b1;
                                pkt.count          = kdl_pkg::COUNT_TWO;
                                pkt.byte0          = kdl_pkg::SYNC_STEP;
                                pkt.byte1          = kdl_pkg::SYNC_MAIN;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Output levels always follow the phase the item leaves behind.
        pkt.motor_open  = (phase_next == kdl_pkg::PH_OPENING);
        pkt.motor_close = (phase_next == kdl_pkg::PH_CLOSING);
        pkt.buzzer      = (phase_next == kdl_pkg::PH_ALARM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= kdl_pkg::PH_WAIT;
            digit_index_reg   <= '0;
            mismatch_seen_reg <= 1'b0;
            fault_count_reg   <= 4'd0;
            tick_count_reg    <= 8'd0;
        end
        else if (in_acc)
        begin
            phase_reg         <= phase_next;
            digit_index_reg   <= digit_index_next;
            mismatch_seen_reg <= mismatch_seen_next;
            fault_count_reg   <= fault_count_next;
            tick_count_reg    <= tick_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            chosen_key_reg <= chosen_key_next;
            if (first_we)
            begin
                first_entry_reg[rd_idx] <= rx_byte;
            end
            if (copy_en)
            begin
                stored_code_reg <= first_entry_reg;
            end
        end
    end

endmodule

>>> src/kdl_out.sv
`timescale 1ns / 1ps

module kdl_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_acc,
    input  kdl_pkg::pkt_t new_pkt,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          tx_valid,
    output logic [7:0]    tx_byte,
    output logic          motor_open,
    output logic          motor_close,
    output logic          buzzer,
    output logic          last
);

    kdl_pkg::pkt_t cur_reg, cur_next;
    kdl_pkg::pkt_t pend_reg, pend_next;
    logic          cur_valid_reg, cur_valid_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [1:0]    slot_reg, slot_next;
    logic          beat;
    logic          last_beat;
    logic          cur_free;

    assign last_beat = (slot_reg == (cur_reg.count - 2'd1));
    assign beat      = cur_valid_reg && !out_stall;
    assign cur_free  = !cur_valid_reg || (beat && last_beat);

    always_comb
    begin
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        cur_valid_next  = cur_valid_reg;
        pend_valid_next = pend_valid_reg;
        slot_next       = slot_reg;

        if (cur_free)
        begin
            slot_next = kdl_pkg::SLOT_0;
            if (pend_valid_reg)
            begin
                cur_next        = pend_reg;
                cur_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (in_acc)
            begin
                cur_next       = new_pkt;
                cur_valid_next = 1'b1;
            end
            else
            begin
                cur_valid_next = 1'b0;
            end
        end
        else
        begin
            if (beat)
            begin
                slot_next = slot_reg + 2'd1;
            end
            if (in_acc)
            begin
                pend_next       = new_pkt;
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            slot_reg       <= kdl_pkg::SLOT_0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= pend_valid_next;
            slot_reg       <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

    always_comb
    begin
        case (slot_reg)
            kdl_pkg::SLOT_0: tx_byte = cur_reg.byte0;
            kdl_pkg::SLOT_1: tx_byte = cur_reg.byte1;
            kdl_pkg::SLOT_2: tx_byte = cur_reg.byte2;
            default:         tx_byte = 8'd0;
        endcase
    end

    assign in_stall    = pend_valid_reg;
    assign out_valid   = cur_valid_reg;
    assign tx_valid    = cur_reg.has_tx;
    assign motor_open  = cur_reg.motor_open;
    assign motor_close = cur_reg.motor_close;
    assign buzzer      = cur_reg.buzzer;
    assign last        = last_beat;

endmodule

>>> src/keypad_door_lock_controller.sv
`timescale 1ns / 1ps
// Result beats are shown from the output packet register. Throughput: one item per cycle
// while each item yields one beat and out_stall is low; an item that yields more beats
// (up to three) holds the result port until its last beat has left the one-beat-per-cycle
// output register. A second packet register takes one more item meanwhile; input beats
// after that are stalled until the current packet has left and the waiting one moves up.
// Reset: rst_n is asynchronous and active low; it returns the lock to waiting for the
// partner's ready byte and loads the registers with 15, 60, 60 and 3.

module keypad_door_lock_controller #(
    parameter int CODE_LENGTH = kdl_pkg::CODE_LENGTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,

    // Input channel: received bytes and one-second ticks.
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] rx_byte,

    // Result channel.
    output logic       out_valid,
    input  logic       out_stall,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       motor_open,
    output logic       motor_close,
    output logic       buzzer,
    output logic       last,

    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]    motor_seconds_reg;
    logic [7:0]    alarm_seconds_reg;
    logic [7:0]    lockout_seconds_reg;
    logic [3:0]    max_faults_reg;
    logic          in_acc;
    kdl_pkg::pkt_t core_pkt;

    // Always writable: the user must write only while the lock is idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_seconds_reg   <= kdl_pkg::MOTOR_SECONDS_RST;
            alarm_seconds_reg   <= kdl_pkg::ALARM_SECONDS_RST;
            lockout_seconds_reg <= kdl_pkg::LOCKOUT_SECONDS_RST;
            max_faults_reg      <= kdl_pkg::MAX_FAULTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kdl_pkg::CFG_MOTOR_SECONDS:   motor_seconds_reg   <= cfg_data;
                kdl_pkg::CFG_ALARM_SECONDS:   alarm_seconds_reg   <= cfg_data;
                kdl_pkg::CFG_LOCKOUT_SECONDS: lockout_seconds_reg <= cfg_data;
                kdl_pkg::CFG_MAX_FAULTS:      max_faults_reg      <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // An input beat is taken whenever the pending packet slot is free. The core
    // decides the whole item in that cycle: it updates the phase, the digit
    // counter, the fault and tick counters and the code stores, and builds the
    // packet of sync bytes and output levels that the item causes.
    assign in_acc = in_valid && !in_stall;

    kdl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_acc          (in_acc),
        .command         (command),
        .rx_byte         (rx_byte),
        .motor_seconds   (motor_seconds_reg),
        .alarm_seconds   (alarm_seconds_reg),
        .lockout_seconds (lockout_seconds_reg),
        .max_faults      (max_faults_reg),
        .pkt             (core_pkt)
    );

    // The output stage plays each packet out one beat per cycle while out_stall is low and
    // marks the final beat of every item with last. A second packet register lets the
    // next item be accepted while the current one still waits on the port.
    kdl_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_acc      (in_acc),
        .new_pkt     (core_pkt),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .motor_open  (motor_open),
        .motor_close (motor_close),
        .buzzer      (buzzer),
        .last        (last)
    );

endmodule
